// ===== rtl/core/dlf_pkg.sv =====
// shared types, constants and helpers for the diode ladder lowpass filter
// no dependencies; imported by every module of the block
package dlf_pkg;

  localparam int WORD_W         = 64;
  localparam int COEF_W         = 32;
  localparam int GAIN_FRAC_BITS = 28;
  localparam int K_FRAC_BITS    = 24;
  localparam int RES_FRAC_BITS  = 16;
  localparam int CUTOFF_W       = 31;
  localparam int RES_W          = 17;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 31'd17594065;
  localparam logic [RES_W-1:0]    RES_RESET    = 17'd65536;
  // 16.998 in q24
  localparam logic signed [COEF_W-1:0] K_SCALE = 32'sd285179118;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES    = 2'd1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPS,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

  // coefficient derivation steps, then per-sample steps
  typedef enum logic [5:0] {
    D_G3, D_D2, D_G2, D_D1, D_G1, D_D0, D_G0,
    D_B0, D_B1, D_B2, D_B3,
    D_SG1, D_SG0, D_GALL, D_GAM0, D_GAM1, D_GAM2,
    D_ALPHA, D_ALPHAH, D_KVAL, D_DEN, D_RECIP,
    S_FB4, S_T2, S_FB3, S_T1, S_FB2, S_T0, S_FBO1,
    S_SG0, S_SG1, S_SG2, S_K, S_UN,
    S_XIN0A, S_XIN0B, S_Z0,
    S_XIN1A, S_XIN1B, S_Z1,
    S_XIN2A, S_XIN2B, S_Z2, S_Z3
  } step_t;

  typedef enum logic [1:0] {
    SH_F,
    SH_K,
    SH_R
  } shift_t;

  typedef struct packed {
    logic   en;
    shift_t sh;
  } mul_ctl_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // saturate to 32-bit two's complement
  function automatic coef_t sat32(input word_t x);
    word_t hi;
    word_t lo;
    hi = word_t'(32'sh7fffffff);
    lo = -word_t'(64'sh80000000);
    if (x > hi) return coef_t'(hi);
    if (x < lo) return coef_t'(lo);
    return x[COEF_W-1:0];
  endfunction

  // shift right by n, rounding half up
  function automatic word_t rsr(input word_t x, input int n);
    word_t t;
    if (n == 0) return x;
    t = x >>> (n - 1);
    return (t + word_t'(1)) >>> 1;
  endfunction

endpackage

// ===== rtl/core/dlf_mul.sv =====
// shared signed 32x32 multiplier with registered product and rounding shift
// depends on dlf_pkg
module dlf_mul
  import dlf_pkg::*;
#(
  parameter int FRAC = 28
) (
  input  logic     clk,
  input  mul_ctl_t ctl,
  input  coef_t    a,
  input  coef_t    b,
  output word_t    res
);

  word_t  prod;
  shift_t sh;

  // product register
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= word_t'(a) * word_t'(b);
      sh   <= ctl.sh;
    end
  end

  // rounding to the selected fraction
  always_comb begin
    case (sh)
      SH_F:    res = rsr(prod, FRAC);
      SH_K:    res = rsr(prod, K_FRAC_BITS);
      SH_R:    res = rsr(prod, RES_FRAC_BITS);
      default: res = prod;
    endcase
  end

endmodule

// ===== rtl/core/dlf_div.sv =====
// unsigned restoring divider, one quotient bit per cycle, quotient saturated
// depends on dlf_pkg
module dlf_div
  import dlf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output div_stat_t         stat,
  output coef_t             quot
);

  localparam int CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] dq;
  logic [WORD_W-1:0] den;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;
  logic              ge;

  // trial subtract
  always_comb begin
    rem_sh = {rem[WORD_W-1:0], dq[WORD_W-1]};
    diff   = rem_sh - {1'b0, den};
    ge     = rem_sh >= {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      dq  <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? diff : rem_sh;
      dq  <= {dq[WORD_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot = (|dq[WORD_W-1:COEF_W-1]) ? coef_t'(32'sh7fffffff) : dq[COEF_W-1:0];

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !busy) else $error("divider started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == CNT_LAST |=> done && !busy) else $error("divider did not finish");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");

endmodule

// ===== rtl/core/diode_ladder_lowpass_filter.sv =====
// four-pole diode ladder lowpass: 22 sequenced steps on one shared multiplier, each through ST_OPS,
// ST_MUL and ST_WB, then ST_DONE loads the result; a new word is taken only after that load
// after any cutoff or resonance write, and after reset, a derivation pass recomputes the
// coefficients: 11 multiplier steps and 11 divider steps
// rst is synchronous: config registers return to defaults, integrator states clear, and the
// derivation pass runs before the first input word is taken
module diode_ladder_lowpass_filter
  import dlf_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CUTOFF_W-1:0]            cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           clipped
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int GL = (F >= GAIN_FRAC_BITS) ? F - GAIN_FRAC_BITS : 0;
  localparam int GR = (F < GAIN_FRAC_BITS) ? GAIN_FRAC_BITS - F : 0;
  localparam int XL = (F >= SAMPLE_WIDTH - 1) ? F - (SAMPLE_WIDTH - 1) : 0;
  localparam int XR = (F < SAMPLE_WIDTH - 1) ? (SAMPLE_WIDTH - 1) - F : 0;
  localparam word_t ONE  = word_t'(1) <<< F;
  localparam word_t SMAX = (word_t'(1) <<< (SAMPLE_WIDTH - 1)) - word_t'(1);
  localparam word_t SMIN = -(word_t'(1) <<< (SAMPLE_WIDTH - 1));

  state_t state;
  state_t state_next;
  step_t  step;

  logic [CUTOFF_W-1:0] cutoff_gain;
  logic [RES_W-1:0]    resonance;

  coef_t cg [4];
  coef_t cbeta [4];
  coef_t cgam [3];
  coef_t csg1, csg0, calpha, calphah, crecip, ckval;
  coef_t z [4];
  word_t d0, d1, d2;
  word_t x, t, acc, lp, fb4, fb3, fb2, fbo1;

  word_t g, hg, gp1, gpre;
  word_t cz;
  word_t opa, opb;
  shift_t opsh;
  coef_t mul_a, mul_b;
  word_t r;
  word_t dnum, dden, nn, dd;
  logic [WORD_W-1:0] dividend, divisor;
  coef_t quot;
  word_t qw;
  word_t xs, ys;
  logic is_div;
  logic cfg_hit;
  logic cfg_pend;
  logic restart;
  logic pass_start;
  logic load_out;

  mul_ctl_t  mul_ctl;
  div_ctl_t  div_ctl;
  div_stat_t div_stat;

  dlf_mul #(.FRAC(F)) u_mul (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (mul_a),
    .b   (mul_b),
    .res (r)
  );

  dlf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .quot     (quot)
  );

  // gain at coefficient scale
  always_comb begin
    cz   = word_t'({33'b0, cutoff_gain});
    gpre = (F >= GAIN_FRAC_BITS) ? (cz <<< GL) : rsr(cz, GR);
    g    = word_t'(sat32(gpre));
    hg   = (g + word_t'(1)) >>> 1;
    gp1  = ONE + g;
    qw   = word_t'(quot);
  end

  // input and output scaling
  always_comb begin
    xs = (F >= SAMPLE_WIDTH - 1) ? (word_t'(sample_in) <<< XL) : rsr(word_t'(sample_in), XR);
    ys = (F >= SAMPLE_WIDTH - 1) ? rsr(lp, XL) : (lp <<< XR);
  end

  assign cfg_hit = cfg_write && (cfg_index == CFG_CUTOFF || cfg_index == CFG_RES);

  // a derivation pass starts from idle or right after the previous pass ends
  assign restart    = cfg_hit || cfg_pend;
  assign pass_start = restart && (state == ST_IDLE || (state == ST_WB && step == D_RECIP));

  // step kind
  always_comb begin
    case (step)
      D_G3, D_G2, D_G1, D_G0, D_B0, D_B1, D_B2, D_B3,
      D_ALPHA, D_ALPHAH, D_RECIP: is_div = 1'b1;
      default:                    is_div = 1'b0;
    endcase
  end

  // multiplier operands per step
  always_comb begin
    opa  = '0;
    opb  = '0;
    opsh = SH_F;
    case (step)
      D_D2:    begin opa = hg; opb = word_t'(cg[3]); end
      D_D1:    begin opa = hg; opb = word_t'(cg[2]); end
      D_D0:    begin opa = g; opb = word_t'(cg[1]); end
      D_SG1:   begin opa = word_t'(cg[3]); opb = word_t'(cg[2]); end
      D_SG0:   begin opa = word_t'(csg1); opb = word_t'(cg[1]); end
      D_GALL:  begin opa = word_t'(csg0); opb = word_t'(cg[0]); end
      D_GAM0:  begin opa = word_t'(cg[0]); opb = word_t'(cg[1]); end
      D_GAM1:  begin opa = word_t'(cg[1]); opb = word_t'(cg[2]); end
      D_GAM2:  begin opa = word_t'(cg[2]); opb = word_t'(cg[3]); end
      D_KVAL:  begin
        opa = word_t'({47'b0, resonance}); opb = word_t'(K_SCALE); opsh = SH_R;
      end
      D_DEN:   begin opa = word_t'(ckval); opb = t; opsh = SH_K; end
      S_FB4:   begin opa = word_t'(cbeta[3]); opb = word_t'(z[3]); end
      S_T2:    begin opa = fb4; opb = hg; end
      S_FB3:   begin opa = word_t'(cbeta[2]); opb = t; end
      S_T1:    begin opa = fb3; opb = hg; end
      S_FB2:   begin opa = word_t'(cbeta[1]); opb = t; end
      S_T0:    begin opa = fb2; opb = g; end
      S_FBO1:  begin opa = word_t'(cbeta[0]); opb = t; end
      S_SG0:   begin opa = word_t'(csg0); opb = fbo1; end
      S_SG1:   begin opa = word_t'(csg1); opb = fb2; end
      S_SG2:   begin opa = word_t'(cg[3]); opb = fb3; end
      S_K:     begin opa = word_t'(ckval); opb = acc; opsh = SH_K; end
      S_UN:    begin opa = x - acc; opb = word_t'(crecip); end
      S_XIN0A: begin opa = acc; opb = word_t'(cgam[0]); end
      S_XIN0B: begin opa = word_t'(cg[1]); opb = fbo1; end
      S_Z0:    begin opa = acc - word_t'(z[0]); opb = word_t'(calpha); end
      S_XIN1A: begin opa = lp; opb = word_t'(cgam[1]); end
      S_XIN1B: begin opa = word_t'(cg[2]); opb = fb2; end
      S_Z1:    begin opa = acc - 2 * word_t'(z[1]); opb = word_t'(calphah); end
      S_XIN2A: begin opa = lp; opb = word_t'(cgam[2]); end
      S_XIN2B: begin opa = word_t'(cg[3]); opb = fb3; end
      S_Z2:    begin opa = acc - 2 * word_t'(z[2]); opb = word_t'(calphah); end
      S_Z3:    begin opa = lp - 2 * word_t'(z[3]); opb = word_t'(calphah); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // divider operands per step
  always_comb begin
    case (step)
      D_G3:     begin dnum = hg; dden = gp1; end
      D_G2:     begin dnum = hg; dden = d2; end
      D_G1:     begin dnum = hg; dden = d1; end
      D_G0:     begin dnum = g; dden = d0; end
      D_B0:     begin dnum = ONE; dden = d0; end
      D_B1:     begin dnum = ONE; dden = d1; end
      D_B2:     begin dnum = ONE; dden = d2; end
      D_B3:     begin dnum = ONE; dden = gp1; end
      D_ALPHA:  begin dnum = g; dden = gp1; end
      D_ALPHAH: begin dnum = g; dden = 2 * gp1; end
      D_RECIP:  begin dnum = ONE; dden = acc; end
      default:  begin dnum = '0; dden = word_t'(1); end
    endcase
    nn = (dnum < 0) ? '0 : dnum;
    dd = (dden < word_t'(1)) ? word_t'(1) : dden;
    dividend = WORD_W'((nn <<< F) + (dd >>> 1));
    divisor  = WORD_W'(dd);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (restart) state_next = ST_OPS;
        else if (in_valid && in_ready) state_next = ST_OPS;
      end
      ST_OPS:  state_next = is_div ? ST_DIV : ST_MUL;
      ST_MUL:  state_next = ST_WB;
      ST_DIV:  if (div_stat.done) state_next = ST_WB;
      ST_WB: begin
        if (step == D_RECIP) state_next = restart ? ST_OPS : ST_IDLE;
        else if (step == S_Z3) state_next = ST_DONE;
        else state_next = ST_OPS;
      end
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready       = (state == ST_IDLE) && !cfg_write && !cfg_pend;
    mul_ctl.en     = (state == ST_MUL);
    mul_ctl.sh     = opsh;
    div_ctl.start  = (state == ST_OPS) && is_div;
    load_out       = (state == ST_DONE) && (!out_valid || out_ready);
  end

  // state, step and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_OPS;
      step      <= D_G3;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        if (restart) step <= D_G3;
        else if (in_valid && in_ready) step <= S_FB4;
      end else if (state == ST_WB && state_next == ST_OPS) begin
        if (step == D_RECIP) step <= D_G3;
        else step <= step_t'(step + 1'b1);
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // a cutoff or resonance write that arrives while busy leaves a derivation pass pending until one starts
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pend <= 1'b0;
    end else if (pass_start) begin
      cfg_pend <= 1'b0;
    end else if (cfg_hit) begin
      cfg_pend <= 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_gain <= CUTOFF_RESET;
      resonance   <= RES_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_CUTOFF) cutoff_gain <= cfg_data;
      else if (cfg_index == CFG_RES) resonance <= cfg_data[RES_W-1:0];
    end
  end

  // integrator states
  always_ff @(posedge clk) begin
    if (rst) begin
      z[0] <= '0;
      z[1] <= '0;
      z[2] <= '0;
      z[3] <= '0;
    end else if (state == ST_WB) begin
      case (step)
        S_Z0:    z[0] <= sat32(word_t'(z[0]) + r + r);
        S_Z1:    z[1] <= sat32(word_t'(z[1]) + r + r);
        S_Z2:    z[2] <= sat32(word_t'(z[2]) + r + r);
        S_Z3:    z[3] <= sat32(word_t'(z[3]) + r + r);
        default: ;
      endcase
    end
  end

  // operand registers, sample capture and step writeback
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) x <= xs;
    if (state == ST_OPS) begin
      mul_a <= sat32(opa);
      mul_b <= sat32(opb);
    end
    if (state == ST_WB) begin
      case (step)
        D_G3:     cg[3] <= quot;
        D_D2:     d2 <= gp1 - r;
        D_G2:     cg[2] <= quot;
        D_D1:     d1 <= gp1 - r;
        D_G1:     cg[1] <= quot;
        D_D0:     d0 <= gp1 - r;
        D_G0:     cg[0] <= quot;
        D_B0:     cbeta[0] <= quot;
        D_B1:     cbeta[1] <= quot;
        D_B2:     cbeta[2] <= quot;
        D_B3:     cbeta[3] <= quot;
        D_SG1:    csg1 <= sat32(r);
        D_SG0:    csg0 <= sat32(r);
        D_GALL:   t <= word_t'(sat32(r));
        D_GAM0:   cgam[0] <= sat32(ONE + r);
        D_GAM1:   cgam[1] <= sat32(ONE + r);
        D_GAM2:   cgam[2] <= sat32(ONE + r);
        D_ALPHA:  calpha <= quot;
        D_ALPHAH: calphah <= quot;
        D_KVAL:   ckval <= r[COEF_W-1:0];
        D_DEN:    acc <= ONE + r;
        D_RECIP:  crecip <= coef_t'(qw);
        S_FB4:    fb4 <= r;
        S_T2:     t <= word_t'(z[2]) + r;
        S_FB3:    fb3 <= r;
        S_T1:     t <= word_t'(z[1]) + r;
        S_FB2:    fb2 <= r;
        S_T0:     t <= word_t'(z[0]) + r;
        S_FBO1:   fbo1 <= r;
        S_SG0:    acc <= r;
        S_SG1:    acc <= acc + r;
        S_SG2:    acc <= acc + r + fb4;
        S_K:      acc <= r;
        S_UN:     acc <= r;
        S_XIN0A:  acc <= r + fb2;
        S_XIN0B:  acc <= acc + r;
        S_Z0:     lp <= r + word_t'(z[0]);
        S_XIN1A:  acc <= r + fb3;
        S_XIN1B:  acc <= acc + r;
        S_Z1:     lp <= r + word_t'(z[1]);
        S_XIN2A:  acc <= r + fb4;
        S_XIN2B:  acc <= acc + r;
        S_Z2:     lp <= r + word_t'(z[2]);
        S_Z3:     lp <= r + word_t'(z[3]);
        default:  ;
      endcase
    end
  end

  // output register with saturation
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (ys > SMAX) begin
        sample_out <= SMAX[SAMPLE_WIDTH-1:0];
        clipped    <= 1'b1;
      end else if (ys < SMIN) begin
        sample_out <= SMIN[SAMPLE_WIDTH-1:0];
        clipped    <= 1'b1;
      end else begin
        sample_out <= ys[SAMPLE_WIDTH-1:0];
        clipped    <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted a word while busy");
  a_busy_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_hit && state == ST_IDLE |=> state == ST_OPS && step == D_G3)
    else $error("coefficient pass not started");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_stat.busy || div_stat.done) else $error("waiting on idle divider");
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && state == ST_IDLE) else $error("result not presented");

endmodule
